FILE: hdl/r2cidr_pkg.sv
// r2cidr_pkg: word types and fixed constants for the range to cidr decomposer
// no dependencies

package r2cidr_pkg;

    // most prefixes given for one range
    localparam int MAX_RESULTS = 62;

    // width used to carry an address between field and internal widths
    localparam int WIDE_BITS = 64;

    // input word: one inclusive address range
    typedef struct packed {
        logic [31:0] range_first;
        logic [31:0] range_last;
    } range_word_t;

    // output word: one cidr block
    typedef struct packed {
        logic [31:0] prefix_base;
        logic [5:0]  prefix_len;
        logic        empty_range;
        logic        final_block;
    } block_word_t;

endpackage

FILE: hdl/range_to_cidr_blocks.sv
// range_to_cidr_blocks: splits an inclusive address range into covering cidr blocks
// depends on r2cidr_pkg for the word types and the result cap
//
// an empty or whole-space range gives its single word from the start state; a two-address
// range gives two full-length blocks, any other range first searches the first block size
// throughput: one range at a time; each block costs one probe per step of the block
// size search, and every probe goes through the single shared probe
// reset: rst_n is asynchronous and active low; it clears the sequencer and the
// output valid, payload registers are not reset

module range_to_cidr_blocks #(
    parameter int ADDRESS_BITS = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     range_valid,
    output logic                     range_ready,
    input  r2cidr_pkg::range_word_t  range_word,
    output logic                     block_valid,
    input  logic                     block_ready,
    output r2cidr_pkg::block_word_t  block_word
);

    import r2cidr_pkg::*;

    localparam int KW  = $clog2(ADDRESS_BITS);
    localparam int N_W = $clog2(MAX_RESULTS + 1);

    localparam logic [ADDRESS_BITS-1:0] ADDR_ONE  = ADDRESS_BITS'(1);
    localparam logic [ADDRESS_BITS-1:0] ADDR_TWO  = ADDRESS_BITS'(2);
    localparam logic [KW-1:0]           K_TOP     = KW'(ADDRESS_BITS - 1);
    localparam logic [6:0]              AB7       = 7'(ADDRESS_BITS);
    localparam logic [N_W-1:0]          N_PAIR    = N_W'(MAX_RESULTS - 2);
    localparam logic [N_W-1:0]          N_LAST    = N_W'(MAX_RESULTS - 1);

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_START  = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_PAIR   = 4'b1000
    } state_t;

    // block size search modes
    typedef enum logic [2:0] {
        MD_CHECK = 3'b001,
        MD_UP    = 3'b010,
        MD_DOWN  = 3'b100
    } mode_t;

    state_t                    state_reg, state_next;
    mode_t                     mode_reg, mode_next;
    logic [ADDRESS_BITS-1:0]   cursor_reg, cursor_next;
    logic [ADDRESS_BITS-1:0]   stop_reg, stop_next;
    logic [ADDRESS_BITS-1:0]   remain_reg, remain_next;
    logic [KW-1:0]             k_reg, k_next;
    logic [N_W-1:0]            n_reg, n_next;
    logic                      out_valid_reg, out_valid_next;
    block_word_t               out_word_reg, out_word_next;

    logic [WIDE_BITS-1:0]      first_wide;
    logic [WIDE_BITS-1:0]      last_wide;
    logic [WIDE_BITS-1:0]      cur_wide;
    logic [WIDE_BITS-1:0]      stop_wide;
    logic [KW-1:0]             probe_idx;
    logic [ADDRESS_BITS-1:0]   probe_size;
    logic [ADDRESS_BITS-1:0]   blk_size;
    logic                      probe_ok;
    logic                      up_room;
    logic                      out_free;
    logic                      out_load;
    logic [6:0]                len7;
    logic                      blk_final;

    // address width conversion
    assign first_wide = WIDE_BITS'(range_word.range_first);
    assign last_wide  = WIDE_BITS'(range_word.range_last);
    assign cur_wide   = WIDE_BITS'(cursor_reg);
    assign stop_wide  = WIDE_BITS'(stop_reg);

    // shared probe: is the cursor aligned to the candidate size and does it fit
    assign up_room    = (k_reg != K_TOP);
    assign probe_idx  = (mode_reg == MD_UP) ? k_reg + KW'(1) : k_reg;
    assign probe_size = ADDR_ONE << probe_idx;
    assign probe_ok   = ((cursor_reg & (probe_size - ADDR_ONE)) == '0)
                        && (probe_size <= remain_reg);

    // chosen block
    assign blk_size  = ADDR_ONE << k_reg;
    assign len7      = AB7 - 7'(k_reg);
    assign blk_final = (remain_reg == blk_size) || (n_reg >= N_LAST);

    // output register can take a word
    assign out_free = !out_valid_reg || block_ready;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        cursor_next   = cursor_reg;
        stop_next     = stop_reg;
        remain_next   = remain_reg;
        k_next        = k_reg;
        n_next        = n_reg;
        out_load      = 1'b0;
        out_word_next = out_word_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (range_valid)
                begin
                    cursor_next = first_wide[ADDRESS_BITS-1:0];
                    stop_next   = last_wide[ADDRESS_BITS-1:0];
                    state_next  = ST_START;
                end
            end
            ST_START:
            begin
                if (stop_reg < cursor_reg)
                begin
                    // empty range: one flagged word
                    if (out_free)
                    begin
                        out_load      = 1'b1;
                        out_word_next = '{prefix_base: '0, prefix_len: '0,
                                          empty_range: 1'b1, final_block: 1'b1};
                        state_next    = ST_IDLE;
                    end
                end
                else if ((cursor_reg == '0) && (stop_reg == '1))
                begin
                    // whole address space
                    if (out_free)
                    begin
                        out_load      = 1'b1;
                        out_word_next = '{prefix_base: '0, prefix_len: '0,
                                          empty_range: 1'b0, final_block: 1'b1};
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    remain_next = stop_reg - cursor_reg + ADDR_ONE;
                    k_next      = '0;
                    n_next      = '0;
                    mode_next   = MD_CHECK;
                    state_next  = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if ((mode_reg == MD_CHECK) && (remain_reg == ADDR_TWO) && (n_reg <= N_PAIR))
                begin
                    // two addresses left: two full-length blocks
                    if (out_free)
                    begin
                        out_load      = 1'b1;
                        out_word_next = '{prefix_base: cur_wide[31:0], prefix_len: AB7[5:0],
                                          empty_range: 1'b0, final_block: 1'b0};
                        n_next        = n_reg + N_W'(1);
                        state_next    = ST_PAIR;
                    end
                end
                else
                begin
                    unique case (mode_reg)
                        MD_CHECK:
                        begin
                            if (probe_ok)
                            begin
                                mode_next = MD_UP;
                            end
                            else
                            begin
                                k_next    = k_reg - KW'(1);
                                mode_next = MD_DOWN;
                            end
                        end
                        MD_UP:
                        begin
                            if (up_room && probe_ok)
                            begin
                                k_next = k_reg + KW'(1);
                            end
                            else if (out_free)
                            begin
                                out_load = 1'b1;
                            end
                        end
                        MD_DOWN:
                        begin
                            if (!probe_ok)
                            begin
                                k_next = k_reg - KW'(1);
                            end
                            else if (out_free)
                            begin
                                out_load = 1'b1;
                            end
                        end
                        default:
                        begin
                            mode_next = MD_CHECK;
                        end
                    endcase

                    // block size settled: give it and, unless it is the last, step past it
                    if (out_load)
                    begin
                        out_word_next = '{prefix_base: cur_wide[31:0], prefix_len: len7[5:0],
                                          empty_range: 1'b0, final_block: blk_final};
                        n_next        = n_reg + N_W'(1);
                        if (blk_final)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            cursor_next = cursor_reg + blk_size;
                            remain_next = remain_reg - blk_size;
                            mode_next   = MD_CHECK;
                        end
                    end
                end
            end
            ST_PAIR:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_word_next = '{prefix_base: stop_wide[31:0], prefix_len: AB7[5:0],
                                      empty_range: 1'b0, final_block: 1'b1};
                    n_next        = n_reg + N_W'(1);
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (block_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MD_CHECK;
            k_reg         <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cursor_reg   <= cursor_next;
        stop_reg     <= stop_next;
        remain_reg   <= remain_next;
        out_word_reg <= out_word_next;
    end

    assign range_ready = (state_reg == ST_IDLE);
    assign block_valid = out_valid_reg;
    assign block_word  = out_word_reg;

    // checks
    a_remain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (remain_reg != '0))
        else $error("search running with nothing left to cover");

    a_cover_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (cursor_reg + remain_reg - ADDR_ONE == stop_reg))
        else $error("cursor and remaining count disagree with range end");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= N_W'(MAX_RESULTS))
        else $error("block count past the cap");

    a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_word_next.final_block) |=> (state_reg == ST_IDLE))
        else $error("final block given but range still in progress");

endmodule

FILE: bench/tb_range_to_cidr_blocks.sv
// tb_range_to_cidr_blocks: self-checking bench for the range to cidr block splitter
// depends on r2cidr_pkg and range_to_cidr_blocks; predicts every block word and
// checks each one in order, under random idling, a long output stall and drain pauses
`timescale 1ns / 1ps

module tb_range_to_cidr_blocks;

    import r2cidr_pkg::*;

    localparam int ADDR_BITS    = 32;
    localparam int LONG_STALL   = 600;
    localparam int DRAIN_SLACK  = 200;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int RANDOM_ITEMS = 240;
    localparam int MAX_PRINTED  = 60;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        range_valid = 1'b0;
    logic        range_ready;
    range_word_t range_word = '0;
    logic        block_valid;
    logic        block_ready = 1'b0;
    block_word_t block_word;

    // blocks still due from ranges already taken, oldest first
    block_word_t pending_blocks[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    // long receiver stall: the stimulus bumps stall_asked, the receiver counts it out
    int          stall_asked = 0;
    int          stall_taken = 0;
    int          stall_left = 0;

    range_to_cidr_blocks #(.ADDRESS_BITS(ADDR_BITS)) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .range_valid (range_valid),
        .range_ready (range_ready),
        .range_word  (range_word),
        .block_valid (block_valid),
        .block_ready (block_ready),
        .block_word  (block_word)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] %s: got %0h expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic void queue_block(input logic [31:0] base, input int len,
                                        input bit is_empty, input bit is_last);
        block_word_t b;
        b.prefix_base = base;
        b.prefix_len  = 6'(len);
        b.empty_range = is_empty;
        b.final_block = is_last;
        pending_blocks = {pending_blocks, b};
    endfunction

    // expected blocks for one range: largest aligned block at the cursor each step
    function automatic void split_range(input logic [31:0] first, input logic [31:0] last);
        logic [32:0] cursor;
        logic [32:0] remain;
        logic [32:0] top;
        int          k;
        int          n;
        bit          busy;
        bit          is_last;
        if (last < first)
            queue_block(32'd0, 0, 1'b1, 1'b1);
        else if (first == 32'd0 && last == 32'hFFFF_FFFF)
            queue_block(32'd0, 0, 1'b0, 1'b1);
        else
        begin
            cursor = {1'b0, first};
            n      = 0;
            busy   = 1'b1;
            while (busy)
            begin
                remain = {1'b0, last} - cursor + 33'd1;
                // two addresses left go out as two full-length blocks while the result cap allows
                if (remain == 33'd2 && n + 2 <= MAX_RESULTS)
                begin
                    queue_block(cursor[31:0], ADDR_BITS, 1'b0, 1'b0);
                    queue_block(last, ADDR_BITS, 1'b0, 1'b1);
                    n    = n + 2;
                    busy = 1'b0;
                end
                else
                begin
                    k = 0;
                    while (k + 1 < ADDR_BITS &&
                           (cursor & ((33'd1 << (k + 1)) - 33'd1)) == 33'd0 &&
                           (33'd1 << (k + 1)) <= remain)
                        k++;
                    top     = cursor + (33'd1 << k) - 33'd1;
                    is_last = (top == {1'b0, last}) || (n + 1 >= MAX_RESULTS);
                    queue_block(cursor[31:0], ADDR_BITS - k, 1'b0, is_last);
                    n++;
                    if (is_last)
                        busy = 1'b0;
                    else
                        cursor = top + 33'd1;
                end
            end
        end
    endfunction

    task automatic check_block(input block_word_t got);
        block_word_t want;
        if (pending_blocks.size() == 0)
            report_mismatch("unexpected block, base", got.prefix_base, 32'd0);
        else
        begin
            want = pending_blocks.pop_front();
            if (got.prefix_base !== want.prefix_base)
                report_mismatch("prefix_base", got.prefix_base, want.prefix_base);
            if (got.prefix_len !== want.prefix_len)
                report_mismatch("prefix_len", 32'(got.prefix_len), 32'(want.prefix_len));
            if (got.empty_range !== want.empty_range)
                report_mismatch("empty_range", 32'(got.empty_range), 32'(want.empty_range));
            if (got.final_block !== want.final_block)
                report_mismatch("final_block", 32'(got.final_block), 32'(want.final_block));
        end
    endtask

    // receiver: random ready, long stall on request, check every accepted word
    always @(posedge clk)
    begin
        if (rst_n && block_valid && block_ready)
            check_block(block_word);
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (stall_asked != stall_taken)
        begin
            stall_taken <= stall_asked;
            stall_left  <= LONG_STALL;
        end
        block_ready <= rst_n && stall_left == 0 && stall_asked == stall_taken &&
                       ($urandom_range(99) >= recv_idle_pct);
    end

    // offer one range, keep valid high until taken, then predict its blocks
    task automatic offer_range(input logic [31:0] first, input logic [31:0] last);
        range_word_t w;
        int          gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            range_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        w.range_first = first;
        w.range_last  = last;
        range_word  <= w;
        range_valid <= 1'b1;
        do
            @(posedge clk);
        while (!range_ready);
        split_range(first, last);
    endtask

    // stop offering and wait for every due block
    task automatic pause_until_drained();
        range_valid <= 1'b0;
        @(posedge clk);
        while (pending_blocks.size() != 0)
            @(posedge clk);
    endtask

    // random range, mostly well-formed spans with a share of odd shapes
    task automatic pick_range(output logic [31:0] first, output logic [31:0] last);
        int          sel;
        int          k;
        int          w;
        logic [31:0] mask;
        sel   = $urandom_range(99);
        first = $urandom;
        last  = $urandom;
        if (sel < 10)
            ; // fully random pair, about half empty
        else if (sel < 15)
        begin
            if (first == 32'd0)
                first = $urandom_range(32'hFFFF_FFFF, 1);
            last = $urandom_range(first - 32'd1, 0);
        end
        else if (sel < 20)
            last = first;
        else if (sel < 25)
        begin
            if (first == 32'hFFFF_FFFF)
                first = first - 32'd1;
            last = first + 32'd1;
        end
        else if (sel < 35)
        begin
            k     = $urandom_range(31, 1);
            mask  = (32'd1 << k) - 32'd1;
            first = first & ~mask;
            last  = first | mask;
        end
        else if (sel < 40)
            last = 32'hFFFF_FFFF;
        else if (sel < 42)
        begin
            first = 32'd0;
            last  = 32'hFFFF_FFFF;
        end
        else
        begin
            w    = $urandom_range(32, 0);
            mask = (w == 0) ? 32'd0 : (32'hFFFF_FFFF >> (32 - w));
            last = first + ($urandom & mask);
            if (last < first)
                last = 32'hFFFF_FFFF;
        end
    endtask

    // fixed corner ranges, no idling
    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        offer_range(32'h0000_0000, 32'hFFFF_FFFF);
        offer_range(32'h0000_0005, 32'h0000_0004);
        offer_range(32'hFFFF_FFFF, 32'h0000_0000);
        offer_range(32'h0000_0000, 32'h0000_0000);
        offer_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_range(32'h0000_000A, 32'h0000_000B);
        offer_range(32'h0000_000B, 32'h0000_000C);
        offer_range(32'h0000_0000, 32'h0000_0001);
        offer_range(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        offer_range(32'h0000_0000, 32'hFFFF_FFFE);
        offer_range(32'h0000_0001, 32'hFFFF_FFFF);
        offer_range(32'h0000_0001, 32'hFFFF_FFFE);
        offer_range(32'h0000_0000, 32'h7FFF_FFFF);
        offer_range(32'h8000_0000, 32'hFFFF_FFFF);
        offer_range(32'h0000_0000, 32'h0000_0002);
        offer_range(32'hC0A8_0000, 32'hC0A8_00FF);
        offer_range(32'h0A00_0001, 32'h0A00_00FE);
        offer_range(32'h0000_0000, 32'h0000_0003);
        offer_range(32'h0000_0001, 32'h0000_0002);
        offer_range(32'h5555_5555, 32'hAAAA_AAAA);
        pause_until_drained();
    endtask

    // random ranges under one idling mix
    task automatic test_random_phase(input int send_pct, input int recv_pct, input int count);
        logic [31:0] first;
        logic [31:0] last;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count)
        begin
            pick_range(first, last);
            offer_range(first, last);
        end
        pause_until_drained();
    endtask

    // receiver holds off for a long stretch while wide ranges keep coming
    task automatic test_output_stall();
        logic [31:0] first;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_asked <= stall_asked + 1;
        repeat (8)
        begin
            first = $urandom_range(32'h0000_0FFF, 1);
            offer_range(first, 32'hFFFF_FFFF - $urandom_range(32'h0000_0FFF, 1));
        end
        pause_until_drained();
    endtask

    // sender stops until the block is empty, then starts again
    task automatic test_drain_pause();
        logic [31:0] first;
        logic [31:0] last;
        send_idle_pct = 20;
        recv_idle_pct = 20;
        repeat (3)
        begin
            pick_range(first, last);
            offer_range(first, last);
            pick_range(first, last);
            offer_range(first, last);
            pause_until_drained();
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(8, 83, RANDOM_ITEMS / 3);
        test_random_phase(83, 8, RANDOM_ITEMS / 3);
        test_random_phase(0, 0, RANDOM_ITEMS / 3);
        test_output_stall();
        test_drain_pause();

        // let any late word show up before the verdict
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (DRAIN_SLACK) @(posedge clk);
        if (pending_blocks.size() != 0)
            report_mismatch("blocks never given", 32'(pending_blocks.size()), 32'd0);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: range_to_cidr_blocks.f
hdl/r2cidr_pkg.sv
hdl/range_to_cidr_blocks.sv
bench/tb_range_to_cidr_blocks.sv
